FILE: src/assert_macros.svh
// Assertion helpers shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising clock edge outside reset
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

FILE: src/cmf_pkg.sv
package cmf_pkg;
   localparam int MAX_HASHES   = 8;
   localparam int COUNTERS     = 65536;
   localparam int COUNTER_BITS = 32;
   localparam int IDX_BITS     = 16;
   localparam int HSEL_BITS    = 3;

   localparam logic [COUNTER_BITS-1:0] CTR_MAX = '1;

   typedef enum logic [1:0] {
      OP_ADD   = 2'd0,
      OP_CHECK = 2'd1,
      OP_COUNT = 2'd2,
      OP_REMOVE = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_ABSENT = 2'd1,
      ST_FEW    = 2'd2
   } status_type;

   localparam logic [1:0] CSR_ACTIVE_HASHES = 2'd0;
   localparam logic [1:0] CSR_COUNTER_COUNT = 2'd1;

   typedef enum logic [3:0] {
      S_IDLE,
      S_CLEAR,
      S_MOD,
      S_MODWAIT,
      S_RD,
      S_RDWAIT,
      S_EVAL,
      S_WR,
      S_DONE
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic clear_wr;     // write zero at clear address
      logic clear_inc;
      logic load;         // capture request
      logic mod_start;    // start reduction of current hash
      logic slot_store;   // store reduced slot
      logic rd;           // read store at current slot
      logic eval;         // evaluate read data
      logic wr;           // write back updated counter
      logic pass_reset;   // reset hash index, start second pass
      logic hash_rewind;  // reset hash index only
      logic next_hash;
      logic finish;       // build result
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic clear_last;
      logic mod_done;
      logic last_hash;
      logic few;
      logic is_add;
      logic is_remove;
      logic absent;       // some picked counter read zero
      logic in_scan;      // presence scan in progress (check, count, first pass of remove)
   } sts_type;
endpackage

FILE: src/cmf_mod.sv
// Serial restoring reduction of a 64-bit hash modulo a 17-bit divisor,
// one quotient bit per cycle.
module cmf_mod import cmf_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] dividend,
   input  logic [16:0] divisor,
   output logic        done,
   output logic [16:0] remainder
);
   logic [63:0] shift_ff, shift_in;
   logic [16:0] rem_ff, rem_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic [17:0] trial;

   assign trial = {rem_ff, shift_ff[63]};

   always_comb begin
      shift_in = shift_ff;
      rem_in   = rem_ff;
      cnt_in   = cnt_ff;
      busy_in  = busy_ff;
      if (start) begin
         shift_in = dividend;
         rem_in   = '0;
         cnt_in   = 7'd0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         shift_in = {shift_ff[62:0], 1'b0};
         if (trial >= {1'b0, divisor}) begin
            rem_in = 17'(trial - {1'b0, divisor});
         end else begin
            rem_in = trial[16:0];
         end
         cnt_in = 7'(cnt_ff + 7'd1);
         if (cnt_ff == 7'd63) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
      rem_ff   <= rem_in;
      cnt_ff   <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   assign done      = busy_ff && !busy_in;
   assign remainder = rem_in;
endmodule

FILE: src/cmf_datapath.sv
`include "assert_macros.svh"
module cmf_datapath import cmf_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   output sts_type     sts,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [16:0] csr_data,
   input  logic [1:0]  req_opcode,
   input  logic [3:0]  req_hashes_given,
   input  logic [63:0] req_hash_0,
   input  logic [63:0] req_hash_1,
   input  logic [63:0] req_hash_2,
   input  logic [63:0] req_hash_3,
   input  logic [63:0] req_hash_4,
   input  logic [63:0] req_hash_5,
   input  logic [63:0] req_hash_6,
   input  logic [63:0] req_hash_7,
   output logic [1:0]  rsp_status,
   output logic [31:0] rsp_min_count,
   output logic [31:0] rsp_items_tally
);
   logic [3:0]  act_ff;
   logic [16:0] cnt_cfg_ff;
   logic [63:0] hash_ff [MAX_HASHES];
   logic [IDX_BITS-1:0] slot_ff [MAX_HASHES];
   logic [1:0]  op_ff;
   logic        few_ff;
   logic [HSEL_BITS-1:0] hi_ff;
   logic [HSEL_BITS-1:0] last_ff;
   logic        absent_ff;
   logic        scan_ff;
   logic [31:0] min_ff;
   logic [31:0] tally_ff;
   logic [IDX_BITS:0] clr_ff;
   logic [COUNTER_BITS-1:0] mem [COUNTERS];
   logic [COUNTER_BITS-1:0] rdata_ff;
   logic [COUNTER_BITS-1:0] wdata;
   logic [IDX_BITS-1:0] waddr;
   logic        mem_we;
   logic [3:0]  eff_k;
   logic [16:0] eff_mod;
   logic        mdone;
   logic [16:0] mrem;

   always_comb begin
      if (act_ff == 4'd0) eff_k = 4'd1;
      else if (act_ff > 4'(MAX_HASHES)) eff_k = 4'(MAX_HASHES);
      else eff_k = act_ff;
      if (cnt_cfg_ff == 17'd0) eff_mod = 17'd1;
      else if (cnt_cfg_ff > 17'(COUNTERS)) eff_mod = 17'(COUNTERS);
      else eff_mod = cnt_cfg_ff;
   end

   cmf_mod u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.mod_start),
      .dividend  (hash_ff[hi_ff]),
      .divisor   (eff_mod),
      .done      (mdone),
      .remainder (mrem)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         act_ff     <= 4'd4;
         cnt_cfg_ff <= 17'(COUNTERS);
      end else if (csr_write) begin
         if (csr_index == CSR_ACTIVE_HASHES) act_ff <= csr_data[3:0];
         else if (csr_index == CSR_COUNTER_COUNT) cnt_cfg_ff <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         hash_ff[0] <= req_hash_0;
         hash_ff[1] <= req_hash_1;
         hash_ff[2] <= req_hash_2;
         hash_ff[3] <= req_hash_3;
         hash_ff[4] <= req_hash_4;
         hash_ff[5] <= req_hash_5;
         hash_ff[6] <= req_hash_6;
         hash_ff[7] <= req_hash_7;
         op_ff      <= req_opcode;
         few_ff     <= req_hashes_given < eff_k;
         last_ff    <= HSEL_BITS'(eff_k - 4'd1);
      end
      if (cmd.slot_store) slot_ff[hi_ff] <= mrem[IDX_BITS-1:0];
   end

   // counter store: one write and one registered read per cycle
   assign mem_we = cmd.clear_wr || cmd.wr;
   assign waddr  = cmd.clear_wr ? clr_ff[IDX_BITS-1:0] : slot_ff[hi_ff];

   always_comb begin
      wdata = rdata_ff;
      if (cmd.clear_wr) begin
         wdata = '0;
      end else if (op_ff == OP_ADD) begin
         if (rdata_ff != CTR_MAX) wdata = rdata_ff + 1'b1;
      end else if (rdata_ff != CTR_MAX && rdata_ff != '0) begin
         wdata = rdata_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[waddr] <= wdata;
      if (cmd.rd) rdata_ff <= mem[slot_ff[hi_ff]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff    <= '0;
         hi_ff     <= '0;
         absent_ff <= 1'b0;
         scan_ff   <= 1'b0;
         min_ff    <= CTR_MAX;
         tally_ff  <= '0;
      end else begin
         if (cmd.clear_inc) clr_ff <= clr_ff + 1'b1;
         if (cmd.load) begin
            hi_ff     <= '0;
            absent_ff <= 1'b0;
            scan_ff   <= req_opcode != OP_ADD;
            min_ff    <= CTR_MAX;
         end
         if (cmd.next_hash) hi_ff <= hi_ff + 1'b1;
         if (cmd.hash_rewind) hi_ff <= '0;
         if (cmd.pass_reset) begin
            hi_ff   <= '0;
            scan_ff <= 1'b0;
         end
         if (cmd.eval && scan_ff) begin
            if (rdata_ff == '0) absent_ff <= 1'b1;
            if (rdata_ff < min_ff) min_ff <= rdata_ff;
         end
         if (cmd.finish && !few_ff) begin
            if (op_ff == OP_ADD) tally_ff <= tally_ff + 1'b1;
            else if (op_ff == OP_REMOVE && !absent_ff) tally_ff <= tally_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         if (few_ff) begin
            rsp_status    <= ST_FEW;
            rsp_min_count <= '0;
         end else if (op_ff != OP_ADD && absent_ff) begin
            rsp_status    <= ST_ABSENT;
            rsp_min_count <= '0;
         end else begin
            rsp_status    <= ST_OK;
            rsp_min_count <= (op_ff == OP_COUNT) ? min_ff : '0;
         end
      end
   end
   assign rsp_items_tally = tally_ff;

   assign sts.clear_last = clr_ff == 17'(COUNTERS - 1);
   assign sts.mod_done   = mdone;
   assign sts.last_hash  = hi_ff == last_ff;
   assign sts.few        = few_ff;
   assign sts.is_add     = op_ff == OP_ADD;
   assign sts.is_remove  = op_ff == OP_REMOVE;
   // includes the counter under evaluation during the scan
   assign sts.absent     = absent_ff || (scan_ff && rdata_ff == '0);
   assign sts.in_scan    = scan_ff;

   `ASSERT_IMPL(a_no_wr_in_scan, clock, reset, cmd.wr, !scan_ff)
   `ASSERT_IMPL(a_one_write_src, clock, reset, cmd.wr, !cmd.clear_wr)
   `ASSERT_NEXT(a_load_clears, clock, reset, cmd.load, hi_ff == '0 && !absent_ff)
endmodule

FILE: src/cmf_ctrl.sv
`include "assert_macros.svh"
module cmf_ctrl import cmf_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   output logic    rsp_valid,
   output cmd_type cmd,
   input  sts_type sts
);
   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLEAR:   if (sts.clear_last) state_in = S_IDLE;
         S_IDLE:    if (start) state_in = S_MOD;
         S_MOD:     state_in = S_MODWAIT;
         S_MODWAIT: begin
            if (sts.mod_done) state_in = sts.last_hash ? S_RD : S_MOD;
         end
         S_RD:      state_in = sts.few ? S_DONE : S_RDWAIT;
         S_RDWAIT:  state_in = S_EVAL;
         S_EVAL: begin
            if (sts.in_scan) begin
               if (!sts.last_hash) state_in = S_RD;
               else if (sts.is_remove) state_in = S_RD;
               else state_in = S_DONE;
            end else begin
               state_in = S_WR;
            end
         end
         S_WR:      state_in = sts.last_hash ? S_DONE : S_RD;
         S_DONE:    state_in = S_IDLE;
         default:   state_in = S_IDLE;
      endcase
      // leave remove after scan when absent
      if (state_ff == S_EVAL && sts.in_scan && sts.last_hash && sts.is_remove
          && (sts.absent)) begin
         state_in = S_DONE;
      end
   end

   always_comb begin
      cmd = '0;
      case (state_ff)
         S_CLEAR: begin
            cmd.clear_wr  = 1'b1;
            cmd.clear_inc = 1'b1;
         end
         S_IDLE:    cmd.load = start;
         S_MOD:     cmd.mod_start = 1'b1;
         S_MODWAIT: begin
            if (sts.mod_done) begin
               cmd.slot_store  = 1'b1;
               cmd.next_hash   = !sts.last_hash;
               cmd.hash_rewind = sts.last_hash;
            end
         end
         S_RD:      cmd.rd = 1'b1;
         S_RDWAIT:  cmd.eval = 1'b0;
         S_EVAL: begin
            cmd.eval = 1'b1;
            if (sts.in_scan) begin
               cmd.next_hash  = !sts.last_hash;
               cmd.pass_reset = sts.last_hash && sts.is_remove;
            end
         end
         S_WR: begin
            cmd.wr        = 1'b1;
            cmd.next_hash = !sts.last_hash;
         end
         S_DONE:    cmd.finish = 1'b1;
         default:   cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_CLEAR;
         rsp_valid <= 1'b0;
      end else begin
         state_ff  <= state_in;
         rsp_valid <= state_ff == S_DONE;
      end
   end

   assign busy = state_ff != S_IDLE;

   `ASSERT_NEXT(a_done_strobe, clock, reset, state_ff == S_DONE, rsp_valid)
   `ASSERT_IMPL(a_wr_not_clear, clock, reset, cmd.wr, state_ff != S_CLEAR)
   `ASSERT_IMPL(a_start_idle, clock, reset, cmd.load, !busy)
endmodule

FILE: src/counting_membership_filter.sv
// channel | direction | handshake
// req_*   | in        | start high while busy low
// rsp_*   | out       | rsp_valid strobe, one cycle
// csr_*   | in        | csr_write, no wait
// After reset a clearing pass zeroes all 65536 counters; busy stays high.
// A transaction: the request is loaded, the modulo unit reduces each active
// hash, a presence scan reads each counter (check, count, remove), an update
// reads and writes back each counter (add, remove), and a done state builds
// the result; too few hashes skip scan and update. The strobe follows in the
// next cycle, where a new start is already taken. The receiver cannot stall it.
module counting_membership_filter import cmf_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [16:0] csr_data,
   input  logic [1:0]  req_opcode,
   input  logic [3:0]  req_hashes_given,
   input  logic [63:0] req_hash_0,
   input  logic [63:0] req_hash_1,
   input  logic [63:0] req_hash_2,
   input  logic [63:0] req_hash_3,
   input  logic [63:0] req_hash_4,
   input  logic [63:0] req_hash_5,
   input  logic [63:0] req_hash_6,
   input  logic [63:0] req_hash_7,
   output logic        rsp_valid,
   output logic [1:0]  rsp_status,
   output logic [31:0] rsp_min_count,
   output logic [31:0] rsp_items_tally
);
   cmd_type cmd;
   sts_type sts;

   cmf_ctrl u_ctrl (
      .clock (clock), .reset (reset), .start (start), .busy (busy),
      .rsp_valid (rsp_valid), .cmd (cmd), .sts (sts)
   );

   cmf_datapath u_dp (
      .clock (clock), .reset (reset), .cmd (cmd), .sts (sts),
      .csr_write (csr_write), .csr_index (csr_index), .csr_data (csr_data),
      .req_opcode (req_opcode), .req_hashes_given (req_hashes_given),
      .req_hash_0 (req_hash_0), .req_hash_1 (req_hash_1),
      .req_hash_2 (req_hash_2), .req_hash_3 (req_hash_3),
      .req_hash_4 (req_hash_4), .req_hash_5 (req_hash_5),
      .req_hash_6 (req_hash_6), .req_hash_7 (req_hash_7),
      .rsp_status (rsp_status), .rsp_min_count (rsp_min_count),
      .rsp_items_tally (rsp_items_tally)
   );
endmodule

FILE: test/testbench.sv
module testbench;
   import cmf_pkg::*;

   typedef struct {
      opcode_type op;
      logic [3:0] given;
      logic [63:0] h [MAX_HASHES];
   } request_type;

   typedef struct {
      status_type status;
      logic [31:0] min_count;
      logic [31:0] tally;
   } answer_type;

   logic clock = 0, reset = 1, start = 0;
   logic busy, rsp_valid;
   logic csr_write = 0;
   logic [1:0] csr_index = '0;
   logic [16:0] csr_data = '0;
   logic [1:0] req_opcode = '0;
   logic [3:0] req_hashes_given = '0;
   logic [63:0] req_hash [MAX_HASHES];
   logic [1:0] rsp_status;
   logic [31:0] rsp_min_count, rsp_items_tally;

   counting_membership_filter uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data),
      .req_opcode(req_opcode), .req_hashes_given(req_hashes_given),
      .req_hash_0(req_hash[0]), .req_hash_1(req_hash[1]), .req_hash_2(req_hash[2]),
      .req_hash_3(req_hash[3]), .req_hash_4(req_hash[4]), .req_hash_5(req_hash[5]),
      .req_hash_6(req_hash[6]), .req_hash_7(req_hash[7]),
      .rsp_valid(rsp_valid), .rsp_status(rsp_status),
      .rsp_min_count(rsp_min_count), .rsp_items_tally(rsp_items_tally));

   always begin
      #1 clock = 1;
      #1 clock = 0;
   end

   // filter shadow: sparse counters, tally, registers
   logic [31:0] counters [int];
   logic [31:0] tally_shadow = '0;
   logic [3:0] hashes_reg = 4'd4;
   logic [16:0] modulus_reg = 17'd65536;

   request_type pending_requests[$];
   answer_type expected_answers[$];
   int errors = 0;
   int sender_idle = 0;
   bit drained = 0;

   function automatic logic [31:0] ctr(int idx);
      return counters.exists(idx) ? counters[idx] : 32'd0;
   endfunction

   function automatic answer_type apply_request(request_type r);
      answer_type a;
      int k, m, i;
      int slot [MAX_HASHES];
      bit present;
      logic [31:0] c;
      k = (hashes_reg == 0) ? 1 : (hashes_reg > MAX_HASHES) ? MAX_HASHES : hashes_reg;
      m = (modulus_reg == 0) ? 1 : (modulus_reg > COUNTERS) ? COUNTERS : modulus_reg;
      a.status = ST_OK;
      a.min_count = '0;
      present = 1;
      for (i = 0; i < k; i++) slot[i] = int'(r.h[i] % 64'(m));
      if (r.given < k) a.status = ST_FEW;
      else if (r.op == OP_ADD) begin
         for (i = 0; i < k; i++) begin
            c = ctr(slot[i]);
            if (c != CTR_MAX) counters[slot[i]] = c + 1;
         end
         tally_shadow++;
      end else begin
         for (i = 0; i < k; i++) if (ctr(slot[i]) == 0) present = 0;
         if (!present) a.status = ST_ABSENT;
         else if (r.op == OP_COUNT) begin
            a.min_count = CTR_MAX;
            for (i = 0; i < k; i++) if (ctr(slot[i]) < a.min_count) a.min_count = ctr(slot[i]);
         end else if (r.op == OP_REMOVE) begin
            for (i = 0; i < k; i++) begin
               c = ctr(slot[i]);
               if (c != CTR_MAX && c != 0) counters[slot[i]] = c - 1;
            end
            tally_shadow--;
         end
      end
      a.tally = tally_shadow;
      return a;
   endfunction

   task automatic report_mismatch(string what);
      $display("mismatch at %0t: %s", $realtime, what);
      errors++;
   endtask

   // driver
   always @(posedge clock) begin
      request_type r;
      if (!reset) begin
         if (start && !busy) begin
            expected_answers.push_back(apply_request(pending_requests.pop_front()));
         end
         if (!(start && busy) && pending_requests.size() > 0 && $urandom_range(99) >= sender_idle
             && !(start && !busy && pending_requests.size() == 0)) begin
            r = pending_requests[0];
            start <= 1;
            req_opcode <= r.op;
            req_hashes_given <= r.given;
            for (int i = 0; i < MAX_HASHES; i++) req_hash[i] <= r.h[i];
         end else if (!(start && busy)) start <= 0;
      end
   end

   // monitor
   always @(posedge clock) begin
      answer_type e;
      if (!reset && rsp_valid) begin
         if (expected_answers.size() == 0) report_mismatch("result with nothing expected");
         else begin
            e = expected_answers.pop_front();
            if (rsp_status !== e.status)
               report_mismatch($sformatf("status %0d want %0d", rsp_status, e.status));
            if (rsp_min_count !== e.min_count)
               report_mismatch($sformatf("min_count %0d want %0d", rsp_min_count, e.min_count));
            if (rsp_items_tally !== e.tally)
               report_mismatch($sformatf("tally %0d want %0d", rsp_items_tally, e.tally));
         end
      end
   end

   function automatic request_type make_request(opcode_type op, logic [3:0] given);
      request_type r;
      r.op = op;
      r.given = given;
      for (int i = 0; i < MAX_HASHES; i++) r.h[i] = {$urandom, $urandom};
      return r;
   endfunction

   // keys drawn from a small pool so checks and removes hit present keys
   request_type key_pool[16];

   function automatic request_type pool_request();
      request_type r;
      int sel;
      sel = $urandom_range(99);
      r = key_pool[$urandom_range(15)];
      r.op = opcode_type'($urandom_range(3));
      r.given = 4'd8;
      if (sel < 10) r = make_request(opcode_type'($urandom_range(3)), 4'($urandom_range(15)));
      else if (sel < 15) r.given = 4'($urandom_range(8));
      return r;
   endfunction

   task automatic wait_idle();
      while (pending_requests.size() > 0 || start || expected_answers.size() > 0)
         @(posedge clock);
      repeat (700) @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [16:0] value);
      csr_write <= 1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      csr_write <= 0;
      if (idx == CSR_ACTIVE_HASHES) hashes_reg = value[3:0];
      else if (idx == CSR_COUNTER_COUNT) modulus_reg = value;
   endtask

   initial begin
      request_type r;
      logic [16:0] moduli [6] = '{17'd1, 17'd2, 17'd7, 17'd300, 17'd65535, 17'd65536};
      logic [3:0] widths [6] = '{4'd1, 4'd8, 4'd3, 4'd0, 4'd15, 4'd5};
      for (int i = 0; i < MAX_HASHES; i++) req_hash[i] = '0;
      repeat (11) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      while (busy) @(posedge clock);

      // directed: field extremes, every opcode, absent, too few, duplicates
      r = make_request(OP_CHECK, 4'd8);
      pending_requests.push_back(r);
      r.op = OP_COUNT;  pending_requests.push_back(r);
      r.op = OP_REMOVE; pending_requests.push_back(r);
      r.op = OP_ADD;    pending_requests.push_back(r);
      pending_requests.push_back(r);
      r.op = OP_COUNT;  pending_requests.push_back(r);
      r.op = OP_REMOVE; pending_requests.push_back(r);
      r.op = OP_CHECK;  pending_requests.push_back(r);
      r.given = 4'd3;   pending_requests.push_back(r);
      r.given = 4'd0;   r.op = OP_ADD; pending_requests.push_back(r);
      r.given = 4'd15;  pending_requests.push_back(r);
      for (int i = 0; i < MAX_HASHES; i++) r.h[i] = '1;
      pending_requests.push_back(r);
      r.op = OP_COUNT;  pending_requests.push_back(r);
      for (int i = 0; i < MAX_HASHES; i++) r.h[i] = '0;
      r.op = OP_ADD;    pending_requests.push_back(r);
      r.op = OP_REMOVE; pending_requests.push_back(r);
      pending_requests.push_back(r);
      wait_idle();

      // duplicate slot removal under modulus 1 (counter goes to zero early)
      write_reg(CSR_COUNTER_COUNT, 17'd1);
      write_reg(CSR_ACTIVE_HASHES, 17'd3);
      r = make_request(OP_ADD, 4'd3);
      pending_requests.push_back(r);
      r.op = OP_REMOVE; pending_requests.push_back(r);
      r.op = OP_CHECK;  pending_requests.push_back(r);
      wait_idle();
      write_reg(CSR_COUNTER_COUNT, 17'd0);
      write_reg(2'd2, 17'h1ffff);
      write_reg(2'd3, 17'd0);
      r.op = OP_COUNT; pending_requests.push_back(r);
      wait_idle();

      for (int phase = 0; phase < 6; phase++) begin
         write_reg(CSR_ACTIVE_HASHES, 17'(widths[phase]));
         write_reg(CSR_COUNTER_COUNT, moduli[phase]);
         case (phase % 4)
            0: sender_idle = 0;
            1: sender_idle = 49;
            2: sender_idle = 19;
            default: sender_idle = 0;
         endcase
         for (int i = 0; i < 16; i++) key_pool[i] = make_request(OP_ADD, 4'd8);
         for (int n = 0; n < 222; n++) pending_requests.push_back(pool_request());
         wait_idle();
      end
      drained = 1;
   end

   initial begin
      wait (drained);
      if (errors == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end

   initial begin
      #20000000;
      $display("status: fail");
      $finish;
   end
endmodule
